### rtl/sts_pkg.sv
package sts_pkg;

    // Token length limit, result and queue sizes, and derived widths
    localparam int MAX_TOKEN   = 1024;
    localparam int LEN_W       = 11;
    localparam int LINE_W      = 16;
    localparam int MAX_RES     = 3;
    localparam int CNT_W       = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [LEN_W-1:0]  LEN_LIMIT = LEN_W'(MAX_TOKEN - 1);
    localparam logic [LINE_W-1:0] LINE_MAX  = '1;
    localparam logic [LINE_W-1:0] LINE_ONE  = LINE_W'(1);

    // Byte codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_APOS   = 8'h27;

    typedef enum logic [1:0] {
        MODE_SKIP,
        MODE_WORD,
        MODE_QUOTE,
        MODE_COMMENT
    } mode_t;

    // One result request
    typedef struct packed {
        logic [7:0]        token_char;
        logic              token_last;
        logic              empty_token;
        logic              was_quoted;
        logic [LINE_W-1:0] line_number;
        logic              script_done;
    } res_t;

    // All results caused by one input byte
    typedef struct packed {
        logic [CNT_W-1:0]         cnt;
        res_t [MAX_RES-1:0]       slot;
    } bundle_t;

endpackage

### rtl/sts_front.sv
module sts_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_script_byte,
    input  logic              s_final_byte,
    input  logic              q_full,
    output logic              push_valid,
    output sts_pkg::bundle_t  push_data
);
    import sts_pkg::*;

    typedef struct packed {
        mode_t                mode;
        logic [7:0]           held_byte;
        logic                 held_valid;
        logic [LEN_W-1:0]     len;
        logic [LINE_W-1:0]    line;
        logic                 discard;
        logic [CNT_W-1:0]     cnt;
        res_t [MAX_RES-1:0]   slot;
    } scan_t;

    mode_t             mode_reg;
    logic [7:0]        prev_reg;
    logic [7:0]        held_byte_reg;
    logic              held_valid_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LINE_W-1:0] line_reg;
    logic              discard_reg;

    scan_t             st_cur;
    scan_t             st_next;
    logic              accept;

    function automatic scan_t f_put(scan_t s, logic [7:0] ch, logic last, logic empty,
                                    logic quoted);
        scan_t r;
        r = s;
        if (s.cnt < CNT_W'(MAX_RES)) begin
            r.slot[s.cnt] = '{token_char: ch, token_last: last, empty_token: empty,
                              was_quoted: quoted, line_number: s.line, script_done: 1'b0};
            r.cnt = s.cnt + CNT_W'(1);
        end
        return r;
    endfunction

    function automatic scan_t f_end(scan_t s, logic quoted);
        scan_t r;
        r = s;
        if (r.held_valid) begin
            r = f_put(r, r.held_byte, 1'b1, 1'b0, quoted);
            r.held_valid = 1'b0;
        end
        r.len = '0;
        return r;
    endfunction

    function automatic scan_t f_append(scan_t s, logic [7:0] b, logic quoted);
        scan_t r;
        r = s;
        if (r.held_valid) begin
            r = f_put(r, r.held_byte, 1'b0, 1'b0, quoted);
        end
        r.held_byte  = b;
        r.held_valid = 1'b1;
        r.len        = r.len + LEN_W'(1);
        if (r.len >= LEN_LIMIT) begin
            r      = f_end(r, quoted);
            r.mode = MODE_SKIP;
            if (quoted) begin
                r.discard = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic f_is_sep(logic [7:0] b, logic [7:0] prev);
        return (b <= CH_SPACE) || (b == CH_EQ) || (b == CH_COMMA && prev != CH_APOS);
    endfunction

    function automatic logic f_is_dropped(logic [7:0] b);
        return (b == CH_SLASH) || (b == CH_LBRACE) || (b == CH_RBRACE);
    endfunction

    function automatic scan_t f_skip(scan_t s, logic [7:0] b, logic [7:0] prev);
        scan_t r;
        r = s;
        if (f_is_sep(b, prev)) begin
            if (b == CH_NL && r.line != LINE_MAX) begin
                r.line = r.line + LINE_W'(1);
            end
        end else begin
            r.held_valid = 1'b0;
            r.len        = '0;
            if (b == CH_SEMI) begin
                r.mode = MODE_COMMENT;
            end else if (b == CH_QUOTE) begin
                r.mode = MODE_QUOTE;
            end else begin
                r.mode = MODE_WORD;
                if (!f_is_dropped(b)) begin
                    r = f_append(r, b, 1'b0);
                end
            end
        end
        return r;
    endfunction

    function automatic scan_t f_word(scan_t s, logic [7:0] b, logic [7:0] prev);
        scan_t r;
        r = s;
        if (f_is_sep(b, prev) || b == CH_SEMI) begin
            r      = f_end(r, 1'b0);
            r.mode = MODE_SKIP;
            r      = f_skip(r, b, prev);
        end else if (!f_is_dropped(b)) begin
            r = f_append(r, b, 1'b0);
        end
        return r;
    endfunction

    // Accept a byte whenever the queue has room for its results
    assign s_ready    = !q_full;
    assign accept     = s_valid && s_ready;
    assign push_valid = accept && (st_next.cnt != '0);
    assign push_data  = '{cnt: st_next.cnt, slot: st_next.slot};

    // Classify one byte and collect the results it causes
    always_comb begin
        st_cur = '{mode: mode_reg, held_byte: held_byte_reg, held_valid: held_valid_reg,
                   len: len_reg, line: line_reg, discard: discard_reg, cnt: '0, slot: '0};
        st_next = st_cur;
        case (mode_reg)
            MODE_SKIP: begin
                if (discard_reg) begin
                    st_next.discard = 1'b0;
                end else begin
                    st_next = f_skip(st_cur, s_script_byte, prev_reg);
                end
            end
            MODE_WORD: begin
                if (prev_reg == CH_SLASH) begin
                    if (s_script_byte == CH_SLASH) begin
                        st_next      = f_end(st_cur, 1'b0);
                        st_next.mode = MODE_COMMENT;
                    end else begin
                        st_next = f_append(st_cur, CH_SLASH, 1'b0);
                        if (st_next.mode == MODE_WORD) begin
                            st_next = f_word(st_next, s_script_byte, prev_reg);
                        end else begin
                            st_next = f_skip(st_next, s_script_byte, prev_reg);
                        end
                    end
                end else begin
                    st_next = f_word(st_cur, s_script_byte, prev_reg);
                end
            end
            MODE_QUOTE: begin
                if (s_script_byte == CH_QUOTE && prev_reg != CH_BSLASH) begin
                    if (held_valid_reg) begin
                        st_next = f_end(st_cur, 1'b1);
                    end else begin
                        st_next = f_put(st_cur, 8'h00, 1'b1, 1'b1, 1'b1);
                    end
                    st_next.len  = '0;
                    st_next.mode = MODE_SKIP;
                end else if (s_script_byte != CH_BSLASH) begin
                    st_next = f_append(st_cur, s_script_byte, 1'b1);
                end
            end
            default: begin
                if (s_script_byte == CH_NL) begin
                    if (line_reg != LINE_MAX) begin
                        st_next.line = line_reg + LINE_W'(1);
                    end
                    st_next.mode = MODE_SKIP;
                end
            end
        endcase

        // Close out the script on its final byte
        if (s_final_byte) begin
            if (st_next.mode == MODE_WORD) begin
                if (s_script_byte == CH_SLASH) begin
                    st_next = f_append(st_next, CH_SLASH, 1'b0);
                end
                st_next = f_end(st_next, 1'b0);
            end else if (st_next.mode == MODE_QUOTE) begin
                if (st_next.held_valid) begin
                    st_next = f_end(st_next, 1'b1);
                end else begin
                    st_next = f_put(st_next, 8'h00, 1'b1, 1'b1, 1'b1);
                end
            end
            if (st_next.cnt == '0) begin
                st_next = f_put(st_next, 8'h00, 1'b0, 1'b0, 1'b0);
            end
            st_next.slot[st_next.cnt - CNT_W'(1)].script_done = 1'b1;
        end
    end

    // Advance scanner state on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_final_byte)) begin
            mode_reg       <= MODE_SKIP;
            prev_reg       <= '0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            len_reg        <= '0;
            line_reg       <= LINE_ONE;
            discard_reg    <= 1'b0;
        end else if (accept) begin
            mode_reg       <= st_next.mode;
            prev_reg       <= s_script_byte;
            held_byte_reg  <= st_next.held_byte;
            held_valid_reg <= st_next.held_valid;
            len_reg        <= st_next.len;
            line_reg       <= st_next.line;
            discard_reg    <= st_next.discard;
        end
    end

    a_final_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_final_byte) |=> (mode_reg == MODE_SKIP && line_reg == LINE_ONE))
        else $error("scanner not reset after final byte");

    a_len_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg < LEN_LIMIT)
        else $error("token length reached limit without ending token");

    a_final_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_final_byte) |-> push_valid)
        else $error("final byte produced no result request");

endmodule

### rtl/sts_queue.sv
module sts_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    input  sts_pkg::bundle_t  push_data,
    output logic              q_full,
    output logic              q_valid,
    output sts_pkg::bundle_t  q_data,
    input  logic              q_pop
);
    import sts_pkg::*;

    bundle_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push_valid && !q_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!push_valid && q_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // Store a bundle at the tail
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Move pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !q_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill level out of range");

endmodule

### rtl/sts_back.sv
module sts_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  sts_pkg::bundle_t  q_data,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output sts_pkg::res_t     m_res
);
    import sts_pkg::*;

    bundle_t           cur_reg;
    bundle_t           cur_next;
    logic              cur_valid_reg;
    logic              cur_valid_next;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    res_t              m_res_reg;
    res_t              m_res_next;
    logic              out_free;
    logic              emit;
    logic              last_slot;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = cur_valid_reg && out_free;
    assign last_slot = ((idx_reg + CNT_W'(1)) == cur_reg.cnt);
    assign q_pop     = q_valid && (!cur_valid_reg || (emit && last_slot));
    assign m_valid   = m_valid_reg;
    assign m_res     = m_res_reg;

    // Walk bundle one result per cycle while out_free; refill from queue
    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        m_res_next     = m_res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        if (emit) begin
            m_res_next   = cur_reg.slot[idx_reg];
            m_valid_next = 1'b1;
            if (last_slot) begin
                cur_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end
        if (q_pop) begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        m_res_reg <= m_res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    a_cur_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (cur_reg.cnt != '0))
        else $error("empty bundle in back stage");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (idx_reg < cur_reg.cnt))
        else $error("slot index past bundle count");

    a_emit_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid_reg)
        else $error("emitted result not presented");

endmodule

### rtl/script_token_splitter.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    s_script_byte[8], s_final_byte
// m_        out  m_valid/m_ready    m_token_char[8], m_token_last, m_empty_token,
//                                   m_was_quoted, m_line_number[16], m_script_done
//
// One script byte is taken per cycle while the queue has room; its one to three
// results, if any, enter a four-deep queue as one request, and the output stage
// sends one result per cycle unless m_ready stalls it, from the output register.
// aresetn is synchronous, active low; no clearing pass is needed.
// s_ready drops only while the result queue is full; m_ready stalls and bytes with
// several results back the queue up until it fills.
module script_token_splitter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_script_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_token_char,
    output logic        m_token_last,
    output logic        m_empty_token,
    output logic        m_was_quoted,
    output logic [15:0] m_line_number,
    output logic        m_script_done
);
    import sts_pkg::*;

    logic    push_valid;
    bundle_t push_data;
    logic    q_full;
    logic    q_valid;
    bundle_t q_data;
    logic    q_pop;
    res_t    m_res;

    sts_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_script_byte (s_script_byte),
        .s_final_byte  (s_final_byte),
        .q_full        (q_full),
        .push_valid    (push_valid),
        .push_data     (push_data)
    );

    sts_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .q_full     (q_full),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop)
    );

    sts_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    // Unpack the result fields
    assign m_token_char  = m_res.token_char;
    assign m_token_last  = m_res.token_last;
    assign m_empty_token = m_res.empty_token;
    assign m_was_quoted  = m_res.was_quoted;
    assign m_line_number = m_res.line_number;
    assign m_script_done = m_res.script_done;

endmodule

### dv/testbench.sv
module testbench;
    import sts_pkg::*;

    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam int IDLE_PCT        = 28;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLDOFF_AT      = 100;
    localparam int HOLDOFF_CYCLES  = 64;
    localparam int CALM_FROM       = 150;
    localparam int CALM_TO         = 300;
    localparam int RANDOM_BYTES    = 350;
    localparam int TAIL_CYCLES     = 10;

    typedef struct {
        logic [7:0] value;
        logic       fin;
        bit         drain_first;
    } script_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_script_byte = 8'h00;
    logic        s_final_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_token_char;
    logic        m_token_last;
    logic        m_empty_token;
    logic        m_was_quoted;
    logic [15:0] m_line_number;
    logic        m_script_done;

    script_item_t script_feed[$];
    res_t         pending_tokens[$];
    res_t         step_tokens[$];
    res_t         oldest_token;
    script_item_t next_item;

    int fail_count = 0;
    int bytes_taken = 0;
    int results_seen = 0;
    int stall_cycles = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;
    int random_bytes = 0;

    // Splitter state as tracked by the predictor
    mode_t             scan_mode_q;
    logic [7:0]        prev_byte_q;
    logic [7:0]        held_byte_q;
    logic              held_q;
    logic [LEN_W-1:0]  tok_len_q;
    logic [LINE_W-1:0] line_q;
    logic              discard_q;

    script_token_splitter i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_script_byte (s_script_byte),
        .s_final_byte  (s_final_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_char  (m_token_char),
        .m_token_last  (m_token_last),
        .m_empty_token (m_empty_token),
        .m_was_quoted  (m_was_quoted),
        .m_line_number (m_line_number),
        .m_script_done (m_script_done)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Token predictor
    // ---------------------------------------------------------------
    function automatic void clear_state();
        scan_mode_q = MODE_SKIP;
        prev_byte_q = 8'h00;
        held_byte_q = 8'h00;
        held_q      = 1'b0;
        tok_len_q   = '0;
        line_q      = LINE_ONE;
        discard_q   = 1'b0;
    endfunction

    function automatic void emit(logic [7:0] ch, logic last, logic empty, logic quoted);
        res_t r;
        if (step_tokens.size() < MAX_RES) begin
            r.token_char  = ch;
            r.token_last  = last;
            r.empty_token = empty;
            r.was_quoted  = quoted;
            r.line_number = line_q;
            r.script_done = 1'b0;
            step_tokens.push_back(r);
        end
    endfunction

    function automatic void close_token(logic quoted);
        if (held_q) begin
            emit(held_byte_q, 1'b1, 1'b0, quoted);
            held_q = 1'b0;
        end
        tok_len_q = '0;
    endfunction

    // Append a byte; the previous held byte goes out as a non-final token byte
    function automatic void add_char(logic [7:0] b, logic quoted);
        if (held_q)
            emit(held_byte_q, 1'b0, 1'b0, quoted);
        held_byte_q = b;
        held_q      = 1'b1;
        tok_len_q   = tok_len_q + LEN_W'(1);
        if (tok_len_q >= LEN_LIMIT) begin
            close_token(quoted);
            scan_mode_q = MODE_SKIP;
            if (quoted)
                discard_q = 1'b1;
        end
    endfunction

    function automatic bit is_gap(logic [7:0] b, logic [7:0] prev);
        return b <= CH_SPACE || b == CH_EQ || (b == CH_COMMA && prev != CH_APOS);
    endfunction

    function automatic void count_line();
        if (line_q != LINE_MAX)
            line_q = line_q + LINE_W'(1);
    endfunction

    function automatic void skip_step(logic [7:0] b, logic [7:0] prev);
        if (is_gap(b, prev)) begin
            if (b == CH_NL)
                count_line();
        end else begin
            held_q    = 1'b0;
            tok_len_q = '0;
            if (b == CH_SEMI) begin
                scan_mode_q = MODE_COMMENT;
            end else if (b == CH_QUOTE) begin
                scan_mode_q = MODE_QUOTE;
            end else begin
                scan_mode_q = MODE_WORD;
                if (b != CH_SLASH && b != CH_LBRACE && b != CH_RBRACE)
                    add_char(b, 1'b0);
            end
        end
    endfunction

    function automatic void word_step(logic [7:0] b, logic [7:0] prev);
        if (is_gap(b, prev) || b == CH_SEMI) begin
            close_token(1'b0);
            scan_mode_q = MODE_SKIP;
            skip_step(b, prev);
        end else if (b != CH_SLASH && b != CH_LBRACE && b != CH_RBRACE) begin
            add_char(b, 1'b0);
        end
    endfunction

    // Work out the results of one accepted request and queue them
    function automatic void split_byte(logic [7:0] b, logic fin);
        logic [7:0] prev;
        prev = prev_byte_q;
        step_tokens.delete();
        case (scan_mode_q)
            MODE_SKIP: begin
                if (discard_q)
                    discard_q = 1'b0;
                else
                    skip_step(b, prev);
            end
            MODE_WORD: begin
                if (prev == CH_SLASH) begin
                    if (b == CH_SLASH) begin
                        close_token(1'b0);
                        scan_mode_q = MODE_COMMENT;
                    end else begin
                        add_char(CH_SLASH, 1'b0);
                        if (scan_mode_q == MODE_WORD)
                            word_step(b, prev);
                        else
                            skip_step(b, prev);
                    end
                end else begin
                    word_step(b, prev);
                end
            end
            MODE_QUOTE: begin
                if (b == CH_QUOTE && prev != CH_BSLASH) begin
                    if (held_q)
                        close_token(1'b1);
                    else
                        emit(8'h00, 1'b1, 1'b1, 1'b1);
                    tok_len_q   = '0;
                    scan_mode_q = MODE_SKIP;
                end else if (b != CH_BSLASH) begin
                    add_char(b, 1'b1);
                end
            end
            default: begin
                if (b == CH_NL) begin
                    count_line();
                    scan_mode_q = MODE_SKIP;
                end
            end
        endcase
        prev_byte_q = b;

        // Flush open tokens at end of script and tag the last result
        if (fin) begin
            if (scan_mode_q == MODE_WORD) begin
                if (b == CH_SLASH)
                    add_char(CH_SLASH, 1'b0);
                close_token(1'b0);
            end else if (scan_mode_q == MODE_QUOTE) begin
                if (held_q)
                    close_token(1'b1);
                else
                    emit(8'h00, 1'b1, 1'b1, 1'b1);
            end
            if (step_tokens.size() == 0)
                emit(8'h00, 1'b0, 1'b0, 1'b0);
            step_tokens[step_tokens.size()-1].script_done = 1'b1;
            clear_state();
        end
        foreach (step_tokens[i])
            pending_tokens.push_back(step_tokens[i]);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    function automatic void add_byte(logic [7:0] b, bit drain_first = 1'b0);
        script_item_t it;
        it.value       = b;
        it.fin         = 1'b0;
        it.drain_first = drain_first;
        script_feed.push_back(it);
    endfunction

    function automatic void add_text(string s, bit fin);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
        if (fin)
            script_feed[script_feed.size()-1].fin = 1'b1;
    endfunction

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 9))
            0: return CH_SLASH;
            1: return CH_LBRACE;
            2: return CH_RBRACE;
            3: return CH_APOS;
            4: return CH_COMMA;
            5: return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(33, 126));
        endcase
    endfunction

    function automatic logic [7:0] gap_char();
        case ($urandom_range(0, 5))
            0: return CH_TAB;
            1: return CH_NL;
            2: return CH_EQ;
            3: return CH_COMMA;
            4: return CH_NUL;
            default: return CH_SPACE;
        endcase
    endfunction

    // One random script: words, quoted strings, comments and noise
    function automatic void add_random_script();
        int pieces;
        int kind;
        int len;
        pieces = $urandom_range(1, 8);
        add_byte(gap_char(), $urandom_range(0, 19) == 0);
        for (int p = 0; p < pieces; p++) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    add_byte(word_char());
                random_bytes += len;
            end else if (kind < 68) begin
                add_byte(CH_QUOTE);
                len = $urandom_range(0, 6);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 9))
                        0: begin
                            add_byte(CH_BSLASH);
                            add_byte(CH_QUOTE);
                        end
                        1: add_byte(CH_BSLASH);
                        2: add_byte(CH_NL);
                        3: add_byte(8'($urandom_range(128, 255)));
                        default: add_byte(8'($urandom_range(32, 126)));
                    endcase
                end
                // leave a few quotes open
                if ($urandom_range(0, 9) != 0)
                    add_byte(CH_QUOTE);
                random_bytes += len + 2;
            end else if (kind < 80) begin
                if ($urandom_range(0, 1)) begin
                    add_byte(CH_SEMI);
                end else begin
                    add_byte(CH_SLASH);
                    add_byte(CH_SLASH);
                end
                len = $urandom_range(0, 5);
                for (int i = 0; i < len; i++)
                    add_byte(8'($urandom_range(32, 126)));
                add_byte(CH_NL);
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    add_byte(8'($urandom_range(0, 255)));
                random_bytes += len;
            end
            len = $urandom_range(0, 2);
            for (int i = 0; i < len; i++)
                add_byte(gap_char());
            random_bytes += len;
        end
        script_feed[script_feed.size()-1].fin = 1'b1;
    endfunction

    function automatic bit calm_stretch();
        return bytes_taken >= CALM_FROM && bytes_taken < CALM_TO;
    endfunction

    // ---------------------------------------------------------------
    // Sender: offer requests from the feed queue, predict on acceptance
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid       <= 1'b0;
            s_script_byte <= 8'h00;
            s_final_byte  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                split_byte(s_script_byte, s_final_byte);
                bytes_taken <= bytes_taken + 1;
            end
            if (!s_valid || s_ready) begin
                if (script_feed.size() != 0
                        && !(script_feed[0].drain_first && pending_tokens.size() != 0)
                        && (calm_stretch() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_item = script_feed.pop_front();
                    s_valid       <= 1'b1;
                    s_script_byte <= next_item.value;
                    s_final_byte  <= next_item.fin;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // ---------------------------------------------------------------
    // Receiver: check each result, stall at random, hold off once
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (pending_tokens.size() == 0) begin
                    $error("unexpected result: token_char %0d line_number %0d",
                           m_token_char, m_line_number);
                    fail_count++;
                end else begin
                    oldest_token = pending_tokens.pop_front();
                    check_field("token_char", oldest_token.token_char, m_token_char);
                    check_field("token_last", oldest_token.token_last, m_token_last);
                    check_field("empty_token", oldest_token.empty_token, m_empty_token);
                    check_field("was_quoted", oldest_token.was_quoted, m_was_quoted);
                    check_field("line_number", oldest_token.line_number, m_line_number);
                    check_field("script_done", oldest_token.script_done, m_script_done);
                end
            end
            if (holdoff_left != 0) begin
                holdoff_left <= holdoff_left - 1;
                m_ready      <= 1'b0;
            end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
                holdoff_done <= 1'b1;
                holdoff_left <= HOLDOFF_CYCLES;
                m_ready      <= 1'b0;
            end else begin
                m_ready <= calm_stretch() || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Fill the feed queue, run reset, wait for the last result
    // ---------------------------------------------------------------
    initial begin
        clear_state();

        // lone slash, double-slash comment, newline count
        add_text("x/y //c\n", 1'b0);
        // braces only, apostrophe comma, semicolon comment
        add_text("{} ',;z\n", 1'b0);
        // high bytes and a NUL separator
        add_byte(8'hFF);
        add_byte(8'h80);
        add_byte(CH_NUL);
        // escaped quote kept, backslash dropped, then an empty quoted token
        add_text("\"a\\\"\"\"\" ", 1'b0);
        // pending slash at end of script
        add_text("q/", 1'b1);
        // open quote with no bytes at end of script
        add_text("\"", 1'b1);
        // bare end marker
        add_text(" ", 1'b1);

        // random scripts, the first after a full drain
        add_byte(CH_SPACE, 1'b1);
        while (random_bytes < RANDOM_BYTES)
            add_random_script();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        do
            @(negedge aclk);
        while (script_feed.size() != 0 || s_valid || pending_tokens.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_tokens.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

### script_token_splitter.f
rtl/sts_pkg.sv
rtl/sts_front.sv
rtl/sts_queue.sv
rtl/sts_back.sv
rtl/script_token_splitter.sv
dv/testbench.sv
